// ===== hdl/ancsm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the case-insensitive substring matcher.
// Shared constants, register indexes and the ASCII case-fold function.
// No dependencies.
package ancsm_pkg;

   localparam int PATTERN_BYTES_DEFAULT = 16;
   localparam int PATTERN_REG_BYTES     = 16;
   localparam int PATTERN_LEN_W         = 5;
   localparam int CSR_DATA_W            = 64;
   localparam int CSR_INDEX_W           = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH   = 2'd2;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;

   // Fold A..Z to a..z, pass every other byte unchanged.
   function automatic logic [7:0] fold_byte(input logic [7:0] b);
      logic [7:0] res;
      res = b;
      if ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) begin
         res = b + (CHAR_LOWER_A - CHAR_UPPER_A);
      end
      return res;
   endfunction

endpackage

// ===== hdl/ancsm_match_cmp.sv =====
`timescale 1ns / 1ps
// Parallel pattern compare against the byte history of the text.
// Uses PATTERN_BYTES from the top level; depends on nothing else.
module ancsm_match_cmp #(
   parameter int PATTERN_BYTES = 16,
   parameter int LEN_W         = $clog2(PATTERN_BYTES + 1)
) (
   input  logic [LEN_W-1:0]                  active_len,
   input  logic [PATTERN_BYTES-1:0][7:0]     pattern_folded,
   input  logic [PATTERN_BYTES-1:0][7:0]     history,
   output logic                              all_equal
);

   localparam int IDX_W = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

   logic [PATTERN_BYTES-1:0] pos_ok;

   // Pattern byte j lines up with the history byte of age len-1-j.
   for (genvar j = 0; j < PATTERN_BYTES; j++) begin : g_pos
      logic [LEN_W-1:0] age;
      logic             needed;
      assign needed    = LEN_W'(j) < active_len;
      assign age       = active_len - LEN_W'(1) - LEN_W'(j);
      assign pos_ok[j] = !needed || (pattern_folded[j] == history[age[IDX_W-1:0]]);
   end

   assign all_equal = &pos_ok;

endmodule

// ===== hdl/ascii_nocase_substring_match.sv =====
`timescale 1ns / 1ps
// Top level of the case-insensitive substring matcher.
// Depends on ancsm_pkg and ancsm_match_cmp.
//
//   channel   direction  handshake        payload
//   req_      in         valid / ready    text_byte[7:0], final_byte, text_empty
//   rsp_      out        valid / ready    contains
//   csr_      in         write_enable     index[1:0], write_data[63:0]
//
// One text byte per cycle when req_ready is high: each item is compared against
// all pattern positions at once and the state advances in the cycle it is accepted.
// An item that ends the text puts its answer in the result register the
// next cycle. req_ready drops only while a result waits and rsp_ready is low.
// Synchronous active-high reset clears control state and the pattern
// registers; the byte window holds no reset value and is never read stale.
module ascii_nocase_substring_match #(
   parameter int PATTERN_BYTES = ancsm_pkg::PATTERN_BYTES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_text_byte,
   input  logic                                 req_final_byte,
   input  logic                                 req_text_empty,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_contains,
   input  logic                                 csr_write_enable,
   input  logic [ancsm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ancsm_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int LEN_W = $clog2(PATTERN_BYTES + 1);

   // Pattern registers
   logic [ancsm_pkg::PATTERN_LEN_W-1:0] pattern_length_ff;
   logic [ancsm_pkg::CSR_DATA_W-1:0]    pattern_low_ff;
   logic [ancsm_pkg::CSR_DATA_W-1:0]    pattern_high_ff;
   logic [2*ancsm_pkg::CSR_DATA_W-1:0]  pattern_regs;

   // Per-text state
   logic [LEN_W-1:0] bytes_seen_ff, bytes_seen_in;
   logic             found_ff, found_in;

   // Result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_contains_ff, rsp_contains_in;

   logic                              req_fire;
   logic                              text_end;
   logic [7:0]                        cur_byte;
   logic [LEN_W-1:0]                  active_len;
   logic [PATTERN_BYTES-1:0][7:0]     pattern_folded;
   logic [PATTERN_BYTES-1:0][7:0]     history;
   logic                              all_equal;
   logic                              seen_enough;
   logic                              hit;

   // Configuration writes; an index past the register list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            ancsm_pkg::CSR_PATTERN_LENGTH: begin
               pattern_length_ff <= csr_write_data[ancsm_pkg::PATTERN_LEN_W-1:0];
            end
            ancsm_pkg::CSR_PATTERN_LOW: begin
               pattern_low_ff <= csr_write_data;
            end
            ancsm_pkg::CSR_PATTERN_HIGH: begin
               pattern_high_ff <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign pattern_regs = {pattern_high_ff, pattern_low_ff};

   // Clamp the length to the pattern storage.
   assign active_len = (int'(pattern_length_ff) > PATTERN_BYTES) ?
                       LEN_W'(PATTERN_BYTES) : LEN_W'(pattern_length_ff);

   // Fold the pattern; bytes past the two registers read as zero.
   for (genvar j = 0; j < PATTERN_BYTES; j++) begin : g_pat
      if (j < ancsm_pkg::PATTERN_REG_BYTES) begin : g_reg
         assign pattern_folded[j] = ancsm_pkg::fold_byte(pattern_regs[8*j +: 8]);
      end else begin : g_zero
         assign pattern_folded[j] = 8'h00;
      end
   end

   assign cur_byte   = ancsm_pkg::fold_byte(req_text_byte);
   assign history[0] = cur_byte;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign text_end  = req_final_byte || req_text_empty;

   // Window of past folded bytes, newest in entry 0. Only entries that the
   // byte count proves written are ever compared, so it needs no clearing.
   if (PATTERN_BYTES > 1) begin : g_win
      logic [PATTERN_BYTES-2:0][7:0] window_ff;

      always_ff @(posedge clock) begin
         if (req_fire && !text_end) begin
            window_ff[0] <= cur_byte;
            for (int k = 1; k < PATTERN_BYTES - 1; k++) begin
               window_ff[k] <= window_ff[k-1];
            end
         end
      end

      for (genvar a = 1; a < PATTERN_BYTES; a++) begin : g_hist
         assign history[a] = window_ff[a-1];
      end
   end

   ancsm_match_cmp #(
      .PATTERN_BYTES (PATTERN_BYTES),
      .LEN_W         (LEN_W)
   ) u_cmp (
      .active_len     (active_len),
      .pattern_folded (pattern_folded),
      .history        (history),
      .all_equal      (all_equal)
   );

   // Match needs len bytes including this one; empty pattern always hits.
   assign seen_enough = ({1'b0, bytes_seen_ff} + (LEN_W + 1)'(1)) >= {1'b0, active_len};
   assign hit         = seen_enough && all_equal;

   always_comb begin
      bytes_seen_in   = bytes_seen_ff;
      found_in        = found_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_contains_in = rsp_contains_ff;
      if (req_fire) begin
         if (text_end) begin
            // Emit the answer and drop the text state.
            rsp_valid_in    = 1'b1;
            rsp_contains_in = req_text_empty ? (active_len == '0) : (found_ff || hit);
            bytes_seen_in   = '0;
            found_in        = 1'b0;
         end else begin
            found_in = found_ff || hit;
            if (bytes_seen_ff != LEN_W'(PATTERN_BYTES)) begin
               bytes_seen_in = bytes_seen_ff + LEN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_contains_ff <= rsp_contains_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_contains = rsp_contains_ff;

   // An item that ends the text always yields a result next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && text_end |=> rsp_valid_ff)
      else $error("text end did not produce a result");

   // Text state is cleared after the end of a text.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && text_end |=> (bytes_seen_ff == '0) && !found_ff)
      else $error("text state not cleared");

   // An empty text matches exactly an empty pattern.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_text_empty |=> rsp_contains_ff == ($past(active_len) == '0))
      else $error("empty text answer wrong");

   // Byte count saturates at the pattern storage size.
   assert property (@(posedge clock) disable iff (reset)
      int'(bytes_seen_ff) <= PATTERN_BYTES)
      else $error("byte count past saturation");

   // A mid-text byte bumps the count unless already saturated.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && !text_end |=> bytes_seen_ff != '0)
      else $error("byte count did not advance");

endmodule

// ===== sim/ascii_nocase_substring_match_tb.sv =====
`timescale 1ns / 1ps
// Testbench for ascii_nocase_substring_match: streams texts through the
// valid/ready request channel and checks each contains answer against a scoreboard.
// Depends on ancsm_pkg and the ascii_nocase_substring_match RTL.
module ascii_nocase_substring_match_tb;

   localparam int          ITEM_TARGET  = 1800;  // random items to send
   localparam int          PHASE_ITEMS  = 130;   // items per pattern setting
   localparam int          DRAIN_CYCLES = 4;     // result is registered in the cycle after the last byte
   localparam int          STALL_LIMIT  = 1000;  // cycles without any transfer
   localparam int          PAT_BYTES    = ancsm_pkg::PATTERN_BYTES_DEFAULT;
   localparam int          IDX_W        = ancsm_pkg::CSR_INDEX_W;
   localparam int          DATA_W       = ancsm_pkg::CSR_DATA_W;
   localparam logic [7:0]  CASE_BIT     = 8'h20;
   localparam logic [7:0]  CHAR_UPPER_A = ancsm_pkg::CHAR_UPPER_A;
   localparam logic [7:0]  CHAR_UPPER_Z = ancsm_pkg::CHAR_UPPER_Z;
   localparam logic [7:0]  CHAR_LOWER_A = ancsm_pkg::CHAR_LOWER_A;
   localparam logic [7:0]  CHAR_LOWER_Z = ancsm_pkg::CHAR_LOWER_A + 8'd25;

   // Scoreboard: mirrors the matcher state and holds the answers it owes.
   class match_tracker;
      int unsigned errors;
      bit          answers_due[$];
      bit [4:0]    len_reg;
      bit [63:0]   low_reg;
      bit [63:0]   high_reg;
      bit [7:0]    window[PAT_BYTES];
      int unsigned seen;
      bit          found;

      function new();
         errors   = 0;
         len_reg  = '0;
         low_reg  = '0;
         high_reg = '0;
         clear_text();
      endfunction

      task report(string what);
         $display("mismatch at %0t ns: %s", $time, what);
         errors++;
      endtask

      function bit [7:0] to_lower(bit [7:0] b);
         if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) return b | CASE_BIT;
         return b;
      endfunction

      function bit [7:0] pattern_byte(int unsigned i);
         if (i < 8) return low_reg[8*i +: 8];
         if (i < 16) return high_reg[8*(i-8) +: 8];
         return 8'h00;
      endfunction

      function void clear_text();
         foreach (window[k]) window[k] = 8'h00;
         seen  = 0;
         found = 1'b0;
      endfunction

      function void note_write(bit [IDX_W-1:0] idx, bit [DATA_W-1:0] data);
         case (idx)
            ancsm_pkg::CSR_PATTERN_LENGTH: len_reg  = data[4:0];
            ancsm_pkg::CSR_PATTERN_LOW:    low_reg  = data;
            ancsm_pkg::CSR_PATTERN_HIGH:   high_reg = data;
            default: ;
         endcase
      endfunction

      // Advance the text state by one accepted item; queue an answer when
      // the item ends the text.
      function void take_byte(bit [7:0] raw, bit last, bit empty);
         int unsigned len;
         bit [7:0]    cur;
         bit          hit;
         len = (len_reg > PAT_BYTES) ? PAT_BYTES : len_reg;
         if (empty) begin
            // An empty text drops whatever was streamed so far.
            answers_due.push_back(len == 0);
            clear_text();
            return;
         end
         cur = to_lower(raw);
         if (len == 0) begin
            hit = 1'b1;
         end else if (seen + 1 < len) begin
            hit = 1'b0;
         end else begin
            hit = (to_lower(pattern_byte(len - 1)) == cur);
            for (int k = 1; k < len; k++)
               if (to_lower(pattern_byte(len - 1 - k)) != window[k-1]) hit = 1'b0;
         end
         if (hit) found = 1'b1;
         for (int k = PAT_BYTES - 1; k > 0; k--) window[k] = window[k-1];
         window[0] = cur;
         if (seen < PAT_BYTES) seen++;
         if (last) begin
            answers_due.push_back(found);
            clear_text();
         end
      endfunction

      task check_answer(bit got);
         bit want;
         if (answers_due.size() == 0) begin
            report($sformatf("contains=%0d with no answer pending", got));
            return;
         end
         want = answers_due.pop_front();
         if (got !== want) report($sformatf("contains=%0d, expected %0d", got, want));
      endtask

      task check_leftover();
         if (answers_due.size() != 0)
            report($sformatf("%0d answers never arrived", answers_due.size()));
      endtask
   endclass

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_ready;
   logic [7:0]         req_text_byte    = 8'h00;
   logic               req_final_byte   = 1'b0;
   logic               req_text_empty   = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready        = 1'b0;
   logic               rsp_contains;
   logic               csr_write_enable = 1'b0;
   logic [IDX_W-1:0]   csr_index        = ancsm_pkg::CSR_PATTERN_LENGTH;
   logic [DATA_W-1:0]  csr_write_data   = '0;

   match_tracker tracker;
   bit           req_calm;          // sender sends back to back
   bit           rsp_calm;          // receiver never stalls
   int unsigned  items_sent;
   int unsigned  stall_count;
   bit [4:0]     pat_len;           // pattern copy used to plant matches
   bit [7:0]     pat[PAT_BYTES];

   ascii_nocase_substring_match DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_final_byte   (req_final_byte),
      .req_text_empty   (req_text_empty),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_contains     (rsp_contains),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #10 clock = ~clock;

   // Monitor: sample every transfer at the rising edge. Check the answer
   // first (it always belongs to an older text), then feed the request,
   // then apply a register write, so a byte sees the registers of before.
   always @(posedge clock) begin
      bit moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid && rsp_ready) begin
            tracker.check_answer(rsp_contains);
            moved = 1'b1;
         end
         if (req_valid && req_ready) begin
            tracker.take_byte(req_text_byte, req_final_byte, req_text_empty);
            moved = 1'b1;
         end
         if (csr_write_enable) begin
            tracker.note_write(csr_index, csr_write_data);
            moved = 1'b1;
         end
         stall_count = moved ? 0 : stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("ascii_nocase_substring_match_tb NOT OK");
            $finish;
         end
      end
   end

   // Receiver: hold ready low for a drawn number of cycles per answer,
   // then keep it high until the answer is taken.
   initial begin
      int unsigned gap;
      forever begin
         gap = rsp_calm ? 0 : $urandom_range(0, 15);
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // Send one item; valid stays high across back-to-back items.
   task automatic send_item(logic [7:0] b, logic last, logic empty);
      int unsigned gap;
      gap = req_calm ? 0 : $urandom_range(0, 15);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_text_byte  = b;
      req_final_byte = last;
      req_text_empty = empty;
      req_valid      = 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Stop sending and wait until every owed answer has come back, then
   // idle for DRAIN_CYCLES so the block can finish a byte that owes nothing.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (tracker.answers_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Load a pattern while idle. Upper bits of the length word are junk
   // at times; only the low five count.
   task automatic set_pattern(bit [4:0] len, bit [63:0] low, bit [63:0] high);
      bit [63:0] len_word;
      len_word = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'h0;
      len_word[4:0] = len;
      drain();
      write_reg(ancsm_pkg::CSR_PATTERN_LENGTH, len_word);
      write_reg(ancsm_pkg::CSR_PATTERN_LOW, low);
      write_reg(ancsm_pkg::CSR_PATTERN_HIGH, high);
      pat_len = len;
      for (int i = 0; i < 8; i++) begin
         pat[i]   = low[8*i +: 8];
         pat[i+8] = high[8*i +: 8];
      end
   endtask

   // Flip the case of a letter at random; leave other bytes alone.
   function automatic logic [7:0] mix_case(logic [7:0] b);
      if ((b | CASE_BIT) >= CHAR_LOWER_A && (b | CASE_BIT) <= CHAR_LOWER_Z)
         return $urandom_range(0, 1) ? (b | CASE_BIT) : (b & ~CASE_BIT);
      return b;
   endfunction

   // Bytes just outside the letter ranges, where folding must not apply.
   function automatic logic [7:0] edge_char();
      case ($urandom_range(0, 3))
         0:       return CHAR_UPPER_A - 8'd1;
         1:       return CHAR_UPPER_Z + 8'd1;
         2:       return CHAR_LOWER_A - 8'd1;
         default: return CHAR_LOWER_Z + 8'd1;
      endcase
   endfunction

   function automatic logic [7:0] any_letter();
      return mix_case(CHAR_LOWER_A + 8'($urandom_range(0, 25)));
   endfunction

   // Filler favors pattern bytes so partial matches and overlaps are common.
   function automatic logic [7:0] filler(int unsigned eff);
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 5 && eff > 0) return mix_case(pat[$urandom_range(0, eff - 1)]);
      if (r < 8) return any_letter();
      if (r == 8) return edge_char();
      return 8'($urandom);
   endfunction

   // Draw a random pattern: mostly short, some full width, some oversized.
   task automatic random_pattern();
      bit [4:0]  len;
      bit [63:0] low;
      bit [63:0] high;
      bit [7:0]  b;
      int unsigned r;
      int unsigned style;
      r = $urandom_range(0, 19);
      if (r == 0)      len = 5'd0;
      else if (r < 3)  len = 5'($urandom_range(17, 31));
      else if (r == 3) len = 5'd16;
      else if (r < 12) len = 5'($urandom_range(1, 4));
      else             len = 5'($urandom_range(1, 16));
      style = $urandom_range(0, 4);
      for (int i = 0; i < 16; i++) begin
         case (style)
            0:       b = 8'($urandom);
            1:       b = mix_case(CHAR_LOWER_A + 8'($urandom_range(0, 1)));
            2:       b = ($urandom_range(0, 4) == 0) ? edge_char() : any_letter();
            3:       b = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
            default: b = any_letter();
         endcase
         if (i < 8) low[8*i +: 8] = b;
         else       high[8*(i-8) +: 8] = b;
      end
      set_pattern(len, low, high);
   endtask

   // Stream one text. A planted copy of the pattern (letters in any case)
   // makes hits likely; now and then an empty item cuts the text short.
   task automatic send_text();
      int unsigned eff;
      int          n;
      int          at;
      bit          cut;
      logic [7:0]  b;
      eff = (pat_len > PAT_BYTES) ? PAT_BYTES : pat_len;
      at  = -1;
      if (eff > 0 && $urandom_range(0, 9) < 6) begin
         n  = eff + $urandom_range(0, 10);
         at = $urandom_range(0, n - eff);
      end else begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
      end
      cut = ($urandom_range(0, 19) == 0);
      for (int i = 0; i < n; i++) begin
         if (at >= 0 && i >= at && i < at + eff) b = mix_case(pat[i-at]);
         else b = filler(eff);
         send_item(b, (i == n - 1) && !cut, 1'b0);
      end
      if (cut || n == 0) send_item(8'($urandom), 1'($urandom), 1'b1);
   endtask

   initial begin
      int unsigned phase_start;
      tracker     = new();
      items_sent  = 0;
      stall_count = 0;
      pat_len     = '0;
      foreach (pat[i]) pat[i] = 8'h00;
      req_calm    = 1'b1;
      rsp_calm    = 1'b0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Directed: empty pattern after reset matches an empty text and a byte.
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hFF, 1'b1, 1'b0);
      // "AbC" found in "xaBc" regardless of case.
      set_pattern(5'd3, 64'h0000_0000_0043_6241, 64'h0);
      send_item(8'h78, 1'b0, 1'b0);
      send_item(8'h61, 1'b0, 1'b0);
      send_item(8'h42, 1'b0, 1'b0);
      send_item(8'h63, 1'b1, 1'b0);
      // Empty text against a non-empty pattern.
      send_item(8'h5A, 1'b1, 1'b1);
      // Empty item mid-text drops "ab", so the trailing "c" cannot match.
      send_item(8'h61, 1'b0, 1'b0);
      send_item(8'h62, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h63, 1'b1, 1'b0);
      // Zero and all-ones bytes are ordinary characters.
      set_pattern(5'd2, 64'h0000_0000_0000_FF00, 64'h0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      // Nine bytes reach into the high register.
      set_pattern(5'd9, 64'h6867_6665_6463_6261, 64'h0000_0000_0000_0049);
      for (int i = 0; i < 8; i++) send_item(8'h41 + 8'(i), 1'b0, 1'b0);
      send_item(8'h69, 1'b1, 1'b0);
      // Pattern changed mid-text: 'Z' went in under "zz", 'Q' meets "zq".
      set_pattern(5'd2, 64'h0000_0000_0000_7A7A, 64'h0);
      send_item(8'h5A, 1'b0, 1'b0);
      set_pattern(5'd2, 64'h0000_0000_0000_717A, 64'h0);
      send_item(8'h51, 1'b1, 1'b0);

      // Random: one pattern per phase, idling style redrawn each phase.
      items_sent = 0;
      while (items_sent < ITEM_TARGET) begin
         random_pattern();
         req_calm    = ($urandom_range(0, 3) == 0);
         rsp_calm    = ($urandom_range(0, 3) == 0);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            send_text();
            if ($urandom_range(0, 29) == 0) drain();
         end
      end

      drain();
      repeat (8) @(posedge clock);
      tracker.check_leftover();
      if (tracker.errors == 0) begin
         $display("ascii_nocase_substring_match_tb OK");
      end else begin
         $display("ascii_nocase_substring_match_tb NOT OK");
      end
      $finish;
   end

endmodule
